// ===== design/ffa_pkg.sv =====
package ffa_pkg;

    localparam int MAX_LINE  = 1024;
    localparam int DRAW_BITS = 16;
    localparam int COL_W     = (MAX_LINE > 2) ? $clog2(MAX_LINE) : 1;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    localparam logic [2:0] REG_CELLS_PER_LINE   = 3'd0;
    localparam logic [2:0] REG_LINE_COUNT       = 3'd1;
    localparam logic [2:0] REG_GROW_THRESHOLD   = 3'd2;
    localparam logic [2:0] REG_IGNITE_THRESHOLD = 3'd3;
    localparam logic [2:0] REG_BURN_DURATION    = 3'd4;

    localparam logic [1:0] ST_EMPTY = 2'd0;
    localparam logic [1:0] ST_TREE  = 2'd1;
    localparam logic [1:0] ST_BURN  = 2'd2;

    localparam logic [0:0] KIND_CELL  = 1'b0;
    localparam logic [0:0] KIND_FLUSH = 1'b1;

    typedef struct packed {
        logic [0:0]  kind;
        logic [1:0]  cell_state;
        logic [7:0]  time_left;
        logic [15:0] random_draw;
    } cell_item_t;

    typedef struct packed {
        logic [1:0] new_state;
        logic [7:0] new_time_left;
        logic [0:0] grid_done;
    } result_item_t;

    // one held-line entry: state, time, threshold hit, burning bit of the line before
    typedef struct packed {
        logic [1:0] state;
        logic [7:0] time_left;
        logic       chance;
        logic       older_burning;
    } line_entry_t;

endpackage

// ===== design/forest_fire_automaton_step.sv =====
// a cell's next state is computed in stage 1 once the cell at the same column of the
// following line (or a flush item in the drain line) is accepted, and is registered in
// the output register before it appears on dst
// throughput: one item per cycle while dst does not stall, set by the two-read one-write line memory
// reset: control registers take their reset values and positions clear at once, no
// clearing pass; the line memory holds no reset value and is filled by line 0 of each grid
module forest_fire_automaton_step
    import ffa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  src_valid,
    output logic                  src_stall,
    input  cell_item_t            src_item,
    output logic                  dst_valid,
    input  logic                  dst_stall,
    output result_item_t          dst_item,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int CMP_W = (COL_W + 1 > 14) ? COL_W + 1 : 14;
    localparam logic [15:0] DRAW_MASK = 16'((64'd1 << DRAW_BITS) - 64'd1);

    typedef struct packed {
        logic             line0;
        logic             drain;
        logic             last;
        logic [COL_W-1:0] col;
        logic [1:0]       cell_state;
        logic [7:0]       time_left;
        logic             chance;
    } stage_t;

    // configuration
    logic [10:0] cpl_reg;
    logic [12:0] lc_reg;
    logic [15:0] grow_reg;
    logic [15:0] ignite_reg;
    logic [7:0]  burn_reg;

    logic       cfg_wr;
    logic [2:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpl_reg    <= 11'd64;
            lc_reg     <= 13'd64;
            grow_reg   <= 16'd0;
            ignite_reg <= 16'd0;
            burn_reg   <= 8'd10;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_CELLS_PER_LINE:   cpl_reg    <= pwdata[10:0];
                REG_LINE_COUNT:       lc_reg     <= pwdata[12:0];
                REG_GROW_THRESHOLD:   grow_reg   <= pwdata[15:0];
                REG_IGNITE_THRESHOLD: ignite_reg <= pwdata[15:0];
                REG_BURN_DURATION:    burn_reg   <= pwdata[7:0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_CELLS_PER_LINE:   prdata = {21'd0, cpl_reg};
            REG_LINE_COUNT:       prdata = {19'd0, lc_reg};
            REG_GROW_THRESHOLD:   prdata = {16'd0, grow_reg};
            REG_IGNITE_THRESHOLD: prdata = {16'd0, ignite_reg};
            REG_BURN_DURATION:    prdata = {24'd0, burn_reg};
            default:              prdata = '0;
        endcase
    end

    // positions
    logic [COL_W-1:0] col_reg, col_next;
    logic [12:0]      line_reg, line_next;
    logic             left_burn_reg, left_burn_next;

    logic [10:0]      cpl_eff;
    logic [12:0]      lc_eff;
    logic [COL_W-1:0] col_cur;
    logic [CMP_W-1:0] col_inc;
    logic [COL_W-1:0] right_addr;
    logic             drain, last, ignore;
    logic [15:0]      draw;
    logic             chance;

    always_comb
    begin
        if (cpl_reg == 11'd0)
            cpl_eff = 11'd1;
        else if (32'(cpl_reg) > MAX_LINE)
            cpl_eff = 11'(MAX_LINE);
        else
            cpl_eff = cpl_reg;
        lc_eff  = (lc_reg == 13'd0) ? 13'd1 : lc_reg;
        col_cur = (CMP_W'(col_reg) >= CMP_W'(cpl_eff)) ? '0 : col_reg;
        col_inc = CMP_W'(col_cur) + CMP_W'(1);
        last    = (col_inc == CMP_W'(cpl_eff));
        right_addr = col_inc[COL_W-1:0];
        drain   = (line_reg >= lc_eff);
        ignore  = (src_item.kind == KIND_FLUSH) && !drain;
        draw    = src_item.random_draw & DRAW_MASK;
        case (src_item.cell_state)
            ST_EMPTY: chance = (draw <= grow_reg);
            ST_TREE:  chance = (draw <= ignite_reg);
            default:  chance = 1'b0;
        endcase
    end

    // pipeline control
    logic   s1_valid_reg, s1_valid_next;
    stage_t s1_reg;
    logic   dst_valid_reg, dst_valid_next;
    result_item_t dst_reg;

    logic src_acc, s1_load, s1_adv;

    assign s1_adv    = s1_valid_reg && (s1_reg.line0 || !dst_valid_reg || !dst_stall);
    assign src_stall = s1_valid_reg && !s1_adv;
    assign src_acc   = src_valid && !src_stall;
    assign s1_load   = src_acc && !ignore;

    always_comb
    begin
        col_next  = col_reg;
        line_next = line_reg;
        if (src_acc && ignore)
            col_next = col_cur;
        else if (s1_load)
        begin
            if (last)
            begin
                col_next  = '0;
                line_next = drain ? 13'd0 : line_reg + 13'd1;
            end
            else
                col_next = col_inc[COL_W-1:0];
        end
    end

    // line memory
    line_entry_t      mem [MAX_LINE];
    line_entry_t      rd_a_reg;
    logic [1:0]       rd_b_reg;
    line_entry_t      wr_word;
    logic             wr_en;

    assign wr_en = s1_adv && !s1_reg.drain;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[s1_reg.col] <= wr_word;
        if (s1_load)
        begin
            // the item leaving stage 1 writes on the same edge
            if (wr_en && s1_reg.col == col_cur)
                rd_a_reg <= wr_word;
            else
                rd_a_reg <= mem[col_cur];
            if (wr_en && s1_reg.col == right_addr)
                rd_b_reg <= wr_word.state;
            else
                rd_b_reg <= mem[right_addr].state;
        end
    end

    // next state of the held cell
    logic             nb_burn;
    result_item_t     res;

    always_comb
    begin
        nb_burn = rd_a_reg.older_burning
                || ((s1_reg.col != '0) && left_burn_reg)
                || (!s1_reg.last && (rd_b_reg == ST_BURN))
                || (!s1_reg.drain && (s1_reg.cell_state == ST_BURN));
        res.new_state     = ST_EMPTY;
        res.new_time_left = 8'd0;
        res.grid_done     = s1_reg.drain && s1_reg.last;
        case (rd_a_reg.state)
            ST_EMPTY:
            begin
                if (rd_a_reg.chance)
                    res.new_state = ST_TREE;
            end
            ST_TREE:
            begin
                if (rd_a_reg.chance || nb_burn)
                begin
                    res.new_state     = ST_BURN;
                    res.new_time_left = burn_reg;
                end
                else
                    res.new_state = ST_TREE;
            end
            ST_BURN:
            begin
                if (rd_a_reg.time_left > 8'd1)
                begin
                    res.new_state     = ST_BURN;
                    res.new_time_left = rd_a_reg.time_left - 8'd1;
                end
            end
            default: ;
        endcase

        wr_word.state         = s1_reg.cell_state;
        wr_word.time_left     = s1_reg.time_left;
        wr_word.chance        = s1_reg.chance;
        wr_word.older_burning = !s1_reg.line0 && (rd_a_reg.state == ST_BURN);

        left_burn_next = left_burn_reg;
        if (s1_adv && !s1_reg.line0)
            left_burn_next = (rd_a_reg.state == ST_BURN);

        s1_valid_next = s1_load ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);

        if (s1_adv && !s1_reg.line0)
            dst_valid_next = 1'b1;
        else
            dst_valid_next = dst_valid_reg && dst_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            line_reg      <= '0;
            left_burn_reg <= 1'b0;
            s1_valid_reg  <= 1'b0;
            dst_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            line_reg      <= line_next;
            left_burn_reg <= left_burn_next;
            s1_valid_reg  <= s1_valid_next;
            dst_valid_reg <= dst_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_reg.line0      <= (line_reg == 13'd0);
            s1_reg.drain      <= drain;
            s1_reg.last       <= last;
            s1_reg.col        <= col_cur;
            s1_reg.cell_state <= src_item.cell_state;
            s1_reg.time_left  <= src_item.time_left;
            s1_reg.chance     <= chance;
        end
        if (s1_adv && !s1_reg.line0)
            dst_reg <= res;
    end

    assign dst_valid = dst_valid_reg;
    assign dst_item  = dst_reg;

endmodule

// ===== tb/forest_fire_automaton_step_tb.sv =====
`timescale 1ns / 1ps

module forest_fire_automaton_step_tb
    import ffa_pkg::*;
();

    localparam int ITEM_W = $bits(cell_item_t);
    localparam logic [1:0] ST_INVALID = 2'd3;

    // tracks one generation of the grid and the next-state items still owed by the block
    class next_gen_board;
        logic [10:0] cells_reg;
        logic [12:0] lines_reg;
        logic [15:0] grow_reg;
        logic [15:0] ignite_reg;
        logic [7:0]  burn_reg;

        logic [1:0] line_state [MAX_LINE];
        logic [7:0] line_time [MAX_LINE];
        bit         line_chance [MAX_LINE];
        bit         older_burn [MAX_LINE];
        int unsigned col_pos;
        int unsigned line_pos;
        bit          left_burn;

        result_item_t next_cells_q[$];
        int errors;

        function new();
            cells_reg  = 11'd64;
            lines_reg  = 13'd64;
            grow_reg   = 16'd0;
            ignite_reg = 16'd0;
            burn_reg   = 8'd10;
            foreach (line_state[i])
            begin
                line_state[i]  = ST_EMPTY;
                line_time[i]   = 8'd0;
                line_chance[i] = 1'b0;
                older_burn[i]  = 1'b0;
            end
            col_pos   = 0;
            line_pos  = 0;
            left_burn = 1'b0;
            errors    = 0;
        endfunction

        function void flag(string msg);
            if (errors < 10)
                $display("%s", msg);
            errors++;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] v);
            case (idx)
                REG_CELLS_PER_LINE:   cells_reg  = v[10:0];
                REG_LINE_COUNT:       lines_reg  = v[12:0];
                REG_GROW_THRESHOLD:   grow_reg   = v[15:0];
                REG_IGNITE_THRESHOLD: ignite_reg = v[15:0];
                REG_BURN_DURATION:    burn_reg   = v[7:0];
                default: ;
            endcase
        endfunction

        function void take_cell(cell_item_t it);
            int unsigned cpl;
            int unsigned lc;
            int unsigned c;
            bit drain;
            bit chance;
            bit up;
            bit left;
            bit right;
            bit down;
            logic [1:0] held_st;
            logic [1:0] ns;
            logic [7:0] held_t;
            logic [7:0] nt;
            bit held_c;
            result_item_t r;

            cpl = (cells_reg == 0) ? 1 : ((cells_reg > MAX_LINE) ? MAX_LINE : cells_reg);
            lc = (lines_reg == 0) ? 1 : lines_reg;
            if (col_pos >= cpl)
                col_pos = 0;
            drain = (line_pos >= lc);
            // flush before the drain line is dropped
            if (it.kind == KIND_FLUSH && !drain)
                return;
            c = col_pos;

            chance = 1'b0;
            if (it.cell_state == ST_EMPTY)
                chance = (it.random_draw <= grow_reg);
            else if (it.cell_state == ST_TREE)
                chance = (it.random_draw <= ignite_reg);

            if (line_pos == 0)
            begin
                line_state[c]  = it.cell_state;
                line_time[c]   = it.time_left;
                line_chance[c] = chance;
                older_burn[c]  = 1'b0;
            end
            else
            begin
                held_st = line_state[c];
                held_t  = line_time[c];
                held_c  = line_chance[c];
                up      = older_burn[c];
                left    = (c > 0) && left_burn;
                right   = (c + 1 < cpl) && (line_state[c + 1] == ST_BURN);
                down    = !drain && (it.cell_state == ST_BURN);
                ns = ST_EMPTY;
                nt = 8'd0;
                case (held_st)
                    ST_EMPTY: ns = held_c ? ST_TREE : ST_EMPTY;
                    ST_TREE:
                    begin
                        if (held_c || up || left || right || down)
                        begin
                            ns = ST_BURN;
                            nt = burn_reg;
                        end
                        else
                            ns = ST_TREE;
                    end
                    ST_BURN:
                    begin
                        if (held_t > 1)
                        begin
                            ns = ST_BURN;
                            nt = held_t - 8'd1;
                        end
                    end
                    default: ;
                endcase

                left_burn = (held_st == ST_BURN);
                if (!drain)
                begin
                    older_burn[c]  = (held_st == ST_BURN);
                    line_state[c]  = it.cell_state;
                    line_time[c]   = it.time_left;
                    line_chance[c] = chance;
                end

                r.new_state     = ns;
                r.new_time_left = nt;
                r.grid_done     = (drain && c + 1 == cpl);
                next_cells_q.push_back(r);
            end

            col_pos = c + 1;
            if (col_pos >= cpl)
            begin
                col_pos  = 0;
                line_pos = drain ? 0 : line_pos + 1;
            end
        endfunction

        function void match_result(result_item_t got);
            result_item_t want;
            if (next_cells_q.size() == 0)
            begin
                flag($sformatf("unexpected result: state %0d time %0d done %0d",
                               got.new_state, got.new_time_left, got.grid_done));
                return;
            end
            want = next_cells_q.pop_front();
            if (got.new_state !== want.new_state || got.new_time_left !== want.new_time_left
                || got.grid_done !== want.grid_done)
                flag($sformatf({"mismatch: expected state %0d time %0d done %0d, ",
                                "got state %0d time %0d done %0d"},
                               want.new_state, want.new_time_left, want.grid_done,
                               got.new_state, got.new_time_left, got.grid_done));
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  src_valid;
    logic                  src_stall;
    cell_item_t            src_item;
    logic                  dst_valid;
    logic                  dst_stall;
    result_item_t          dst_item;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    next_gen_board sb;
    int src_idle_mode;
    int dst_idle_mode;
    int choke_len;
    int cells_run;

    forest_fire_automaton_step uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_item  (src_item),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_item  (dst_item),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic cell_item_t mk_cell(logic k, logic [1:0] s, logic [7:0] t, logic [15:0] d);
        cell_item_t it;
        it.kind        = k;
        it.cell_state  = s;
        it.time_left   = t;
        it.random_draw = d;
        return it;
    endfunction

    function automatic cell_item_t rand_cell();
        cell_item_t it;
        int r;
        it = ITEM_W'($urandom);
        it.kind = KIND_CELL;
        r = $urandom_range(0, 19);
        if (r < 6)
            it.cell_state = ST_EMPTY;
        else if (r < 13)
            it.cell_state = ST_TREE;
        else if (r < 19)
            it.cell_state = ST_BURN;
        else
            it.cell_state = ST_INVALID;
        if (it.cell_state == ST_BURN && $urandom_range(0, 1))
            it.time_left = 8'($urandom_range(0, 4));
        // hit the threshold exactly now and then
        if ($urandom_range(0, 9) == 0)
            it.random_draw = (it.cell_state == ST_EMPTY) ? sb.grow_reg : sb.ignite_reg;
        return it;
    endfunction

    function automatic logic [15:0] pick_level();
        case ($urandom_range(0, 4))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(0, 16'h2000));
            default: return 16'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    function automatic logic [7:0] pick_burn();
        case ($urandom_range(0, 3))
            0: return 8'd0;
            1: return 8'd1;
            2: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic read_reg(input logic [2:0] idx, output logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        data = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        logic [31:0] mask;
        logic [31:0] rd;
        case (idx)
            REG_CELLS_PER_LINE:   mask = 32'h7FF;
            REG_LINE_COUNT:       mask = 32'h1FFF;
            REG_BURN_DURATION:    mask = 32'hFF;
            default:              mask = 32'hFFFF;
        endcase
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.set_reg(idx, value & mask);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        read_reg(idx, rd);
        if (rd !== (value & mask))
            sb.flag($sformatf("register %0d readback: expected %0h, got %0h",
                              idx, value & mask, rd));
    endtask

    // no item in flight: sender quiet, every owed result received, pipeline drained
    task automatic settle();
        @(negedge clk);
        src_valid <= 1'b0;
        while (sb.next_cells_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic send_cell(input cell_item_t it);
        int gap;
        gap = src_idle_mode ? $urandom_range(0, 19) : 0;
        repeat (gap)
        begin
            @(negedge clk);
            src_valid <= 1'b0;
        end
        @(negedge clk);
        src_valid <= 1'b1;
        src_item  <= it;
        do
            @(posedge clk);
        while (src_stall);
        sb.take_cell(it);
    endtask

    task automatic setup_grid(input logic [31:0] cells, input logic [31:0] lines,
                              input logic [15:0] grow, input logic [15:0] ign,
                              input logic [7:0] burn);
        settle();
        write_reg(REG_CELLS_PER_LINE, cells);
        write_reg(REG_LINE_COUNT, lines);
        write_reg(REG_GROW_THRESHOLD, grow);
        write_reg(REG_IGNITE_THRESHOLD, ign);
        write_reg(REG_BURN_DURATION, burn);
    endtask

    // full grid plus drain line; stray flush items mixed into the grid lines
    task automatic stream_grid(input int cpl, input int lc);
        cell_item_t it;
        for (int ln = 0; ln < lc; ln++)
        begin
            for (int c = 0; c < cpl; c++)
            begin
                if ($urandom_range(0, 29) == 0)
                begin
                    it = ITEM_W'($urandom);
                    it.kind = KIND_FLUSH;
                    send_cell(it);
                end
                send_cell(rand_cell());
                cells_run++;
            end
        end
        for (int c = 0; c < cpl; c++)
        begin
            if ($urandom_range(0, 4) == 0)
                it = rand_cell();
            else
            begin
                it = ITEM_W'($urandom);
                it.kind = KIND_FLUSH;
            end
            send_cell(it);
            cells_run++;
        end
    endtask

    initial
    begin
        int n;
        n = 0;
        forever
        begin
            if (choke_len > 0)
            begin
                n = choke_len;
                choke_len = 0;
            end
            else
                n = dst_idle_mode ? $urandom_range(0, 19) : 0;
            repeat (n)
            begin
                @(negedge clk);
                dst_stall <= 1'b1;
            end
            @(negedge clk);
            dst_stall <= 1'b0;
            do
                @(posedge clk);
            while (!dst_valid);
            sb.match_result(dst_item);
        end
    end

    initial
    begin
        logic [31:0] rd;
        int cpl;
        int lc;

        sb = new();
        rst_n     = 1'b0;
        src_valid = 1'b0;
        src_item  = '0;
        dst_stall = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        src_idle_mode = 1;
        dst_idle_mode = 1;
        choke_len = 0;
        cells_run = 0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset values of the registers
        read_reg(REG_CELLS_PER_LINE, rd);
        if (rd !== 32'd64)
            sb.flag($sformatf("cells_per_line after reset: got %0h", rd));
        read_reg(REG_LINE_COUNT, rd);
        if (rd !== 32'd64)
            sb.flag($sformatf("line_count after reset: got %0h", rd));
        read_reg(REG_GROW_THRESHOLD, rd);
        if (rd !== 32'd0)
            sb.flag($sformatf("grow_threshold after reset: got %0h", rd));
        read_reg(REG_IGNITE_THRESHOLD, rd);
        if (rd !== 32'd0)
            sb.flag($sformatf("ignite_threshold after reset: got %0h", rd));
        read_reg(REG_BURN_DURATION, rd);
        if (rd !== 32'd10)
            sb.flag($sformatf("burn_duration after reset: got %0h", rd));

        // thresholds hit exactly, invalid state, flush mid-grid, cell in drain line
        setup_grid(3, 2, 16'h8000, 16'h0100, 8'd255);
        send_cell(mk_cell(KIND_CELL, ST_TREE, 8'd0, 16'hFFFF));
        send_cell(mk_cell(KIND_CELL, ST_BURN, 8'd1, 16'h0000));
        send_cell(mk_cell(KIND_CELL, ST_EMPTY, 8'd0, 16'h8000));
        send_cell(mk_cell(KIND_FLUSH, ST_BURN, 8'd255, 16'h0000));
        send_cell(mk_cell(KIND_CELL, ST_TREE, 8'd0, 16'h0100));
        send_cell(mk_cell(KIND_CELL, ST_EMPTY, 8'd200, 16'h8001));
        send_cell(mk_cell(KIND_CELL, ST_INVALID, 8'd255, 16'h0000));
        send_cell(mk_cell(KIND_FLUSH, ST_EMPTY, 8'd0, 16'h0000));
        send_cell(mk_cell(KIND_CELL, ST_BURN, 8'd7, 16'h0000));
        send_cell(mk_cell(KIND_FLUSH, ST_INVALID, 8'd255, 16'hFFFF));

        // zero burn duration, ignition always, growth never
        setup_grid(2, 3, 16'h0000, 16'hFFFF, 8'd0);
        send_cell(mk_cell(KIND_CELL, ST_TREE, 8'd0, 16'hFFFF));
        send_cell(mk_cell(KIND_CELL, ST_BURN, 8'd255, 16'h1234));
        send_cell(mk_cell(KIND_CELL, ST_BURN, 8'd2, 16'h0000));
        send_cell(mk_cell(KIND_CELL, ST_TREE, 8'd0, 16'h0000));
        send_cell(mk_cell(KIND_CELL, ST_TREE, 8'd0, 16'h0000));
        send_cell(mk_cell(KIND_CELL, ST_EMPTY, 8'd0, 16'hFFFF));
        send_cell(mk_cell(KIND_FLUSH, ST_EMPTY, 8'd0, 16'h0000));
        send_cell(mk_cell(KIND_FLUSH, ST_EMPTY, 8'd0, 16'h0000));

        // zero line length and zero line count act as one
        setup_grid(0, 0, pick_level(), pick_level(), pick_burn());
        stream_grid(1, 1);

        // line length above the buffer size is clamped
        setup_grid(2047, 1, 16'h4000, 16'h0400, 8'd3);
        stream_grid(MAX_LINE, 1);

        // single-cell lines back to back, no idling
        src_idle_mode = 0;
        dst_idle_mode = 0;
        setup_grid(1, 64, 16'h8000, 16'h1000, 8'd2);
        stream_grid(1, 64);
        src_idle_mode = 1;
        dst_idle_mode = 1;

        // shrink line length, then line count, in the middle of a grid
        setup_grid(6, 4, 16'h6000, 16'h0800, 8'd4);
        for (int i = 0; i < 9; i++)
            send_cell(rand_cell());
        settle();
        write_reg(REG_CELLS_PER_LINE, 3);
        for (int i = 0; i < 3; i++)
            send_cell(rand_cell());
        settle();
        write_reg(REG_LINE_COUNT, 1);
        for (int i = 0; i < 3; i++)
            send_cell(mk_cell(KIND_FLUSH, ST_EMPTY, 8'd0, 16'h0000));

        // receiver holds off while the sender keeps pushing
        src_idle_mode = 0;
        setup_grid(16, 8, 16'h3000, 16'h0200, 8'd5);
        choke_len = 400;
        stream_grid(16, 8);
        src_idle_mode = 1;

        cells_run = 0;
        while (cells_run < 1000)
        begin
            cpl = ($urandom_range(0, 19) < 14) ? $urandom_range(1, 8) : $urandom_range(9, 40);
            lc = ($urandom_range(0, 19) < 15) ? $urandom_range(1, 6) : $urandom_range(7, 20);
            src_idle_mode = ($urandom_range(0, 3) != 0);
            dst_idle_mode = ($urandom_range(0, 3) != 0);
            setup_grid(cpl, lc, pick_level(), pick_level(), pick_burn());
            stream_grid(cpl, lc);
        end

        settle();
        repeat (20) @(posedge clk);
        if (sb.next_cells_q.size() != 0)
            sb.flag($sformatf("%0d results never arrived", sb.next_cells_q.size()));
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
